### rtl/matrix4x4_row_multiply_assert.svh
// Assertion macros for the row multiplier checker.
// Depends on nothing; every property is clocked on i_clk and held off in reset.
`ifndef MATRIX4X4_ROW_MULTIPLY_ASSERT_SVH
`define MATRIX4X4_ROW_MULTIPLY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mrm_pkg.sv
// Shared types and constants for the 4x4 row multiplier.
// Used by the cell, the rounding stage and the top level.
`default_nettype none

package mrm_pkg;

    localparam int unsigned N_DIM     = 4;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PROD_W    = 2 * WORD_W;
    localparam int unsigned ACC_W     = PROD_W + 2;
    localparam int unsigned ROW_SEL_W = 2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [ACC_W-1:0]  t_acc;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } t_op;

    // One request as it moves down the chain of cells
    typedef struct packed {
        t_op                    op;
        logic [ROW_SEL_W-1:0]   row_sel;
        t_word [N_DIM-1:0]      elem;
        t_acc  [N_DIM-1:0]      sum;
        t_prod [N_DIM-1:0]      prod;
    } t_stage;

    localparam t_word SAT_POS = 32'h7FFF_FFFF;
    localparam t_word SAT_NEG = 32'h8000_0000;

endpackage

`default_nettype wire

### rtl/mrm_cell.sv
// One cell of the chain: holds one row of the right matrix, forms four products
// with its left element and folds the previous cell's products into the sums.
// Depends on mrm_pkg.
`default_nettype none

module mrm_cell
    import mrm_pkg::*;
#(
    parameter int unsigned ROW_IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_ready,
    input  logic   i_next_ready,
    output logic   o_valid,
    output t_stage o_stage
);

    localparam logic [ROW_SEL_W-1:0] ROW_SEL = ROW_SEL_W'(ROW_IDX);

    t_word [N_DIM-1:0]        r_row;
    logic                     r_valid;
    t_stage                   r_stage;
    t_stage                   n_stage;
    logic signed [WORD_W-1:0] w_lhs;
    logic signed [PROD_W-1:0] w_prod [N_DIM];
    logic                     w_take;
    logic                     w_write;

    assign o_ready = !r_valid || i_next_ready;
    assign w_take  = i_valid && o_ready;
    assign w_write = w_take && (i_stage.op == OP_LOAD) && (i_stage.row_sel == ROW_SEL);
    assign w_lhs   = $signed(i_stage.elem[ROW_SEL]);

    always_comb begin
        n_stage = i_stage;
        for (int j = 0; j < N_DIM; j++) begin
            w_prod[j] = w_lhs * $signed(r_row[j]);
            // previous cell's product joins the running sum here
            n_stage.sum[j]  = i_stage.sum[j]
                            + {{(ACC_W-PROD_W){i_stage.prod[j][PROD_W-1]}}, i_stage.prod[j]};
            n_stage.prod[j] = t_prod'(w_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (w_write) begin
            r_row <= i_stage.elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

### rtl/mrm_round.sv
// Last stage: adds the final products, shifts out the fraction, saturates to
// 32 bits and holds the result row. Load requests are dropped here.
// Depends on mrm_pkg.
`default_nettype none

module mrm_round
    import mrm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_stage            i_stage,
    output logic              o_ready,
    input  logic              i_ready,
    output logic              o_valid,
    output t_word [N_DIM-1:0] o_prod,
    output logic              o_saturated
);

    logic              r_valid;
    t_word [N_DIM-1:0] r_prod;
    logic              r_saturated;
    t_word [N_DIM-1:0] n_prod;
    logic              n_saturated;
    t_acc              w_total [N_DIM];
    t_acc              w_shift [N_DIM];
    logic [N_DIM-1:0]  w_fits;
    logic              w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready && (i_stage.op == OP_MUL);

    always_comb begin
        n_saturated = 1'b0;
        for (int j = 0; j < N_DIM; j++) begin
            w_total[j] = i_stage.sum[j]
                       + {{(ACC_W-PROD_W){i_stage.prod[j][PROD_W-1]}}, i_stage.prod[j]};
            w_shift[j] = ACC_W'($signed(w_total[j]) >>> FRAC_BITS);
            // fits when every bit above the result's sign matches it
            w_fits[j]  = (&w_shift[j][ACC_W-1:WORD_W-1]) || !(|w_shift[j][ACC_W-1:WORD_W-1]);
            if (w_fits[j]) begin
                n_prod[j] = w_shift[j][WORD_W-1:0];
            end else if (w_total[j][ACC_W-1]) begin
                n_prod[j] = SAT_NEG;
            end else begin
                n_prod[j] = SAT_POS;
            end
            n_saturated = n_saturated || !w_fits[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && (i_stage.op == OP_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prod      <= n_prod;
            r_saturated <= n_saturated;
        end
    end

    assign o_valid     = r_valid;
    assign o_prod      = r_prod;
    assign o_saturated = r_saturated;

endmodule

`default_nettype wire

### rtl/matrix4x4_row_multiply.sv
// Top level of the 4x4 Q16.16 row multiplier: four chained cells and a rounding stage.
// Depends on mrm_pkg, mrm_cell and mrm_round.
//
// The block takes one request per cycle unless a stalled output backs up the chain. Each
// multiply result passes the chain of four cells (one row of the right matrix each) and the
// output register. A load request writes its row as it passes the matching cell, so every
// multiply sees exactly the loads accepted before it. Loads give no result. The right
// matrix sits in flip-flops and reads as zero after reset with no clearing pass. A full
// output register stalls the chain only as far back as there are no empty stages.
`default_nettype none

module matrix4x4_row_multiply
    import mrm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic [1:0]         i_row_select,
    input  logic signed [31:0] i_elem_0,
    input  logic signed [31:0] i_elem_1,
    input  logic signed [31:0] i_elem_2,
    input  logic signed [31:0] i_elem_3,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_prod_0,
    output logic signed [31:0] o_prod_1,
    output logic signed [31:0] o_prod_2,
    output logic signed [31:0] o_prod_3,
    output logic               o_saturated
);

    t_stage            w_head;
    t_stage            w_stage [N_DIM+1];
    logic [N_DIM:0]    w_valid;
    logic [N_DIM:0]    w_ready;
    t_word [N_DIM-1:0] w_prod;

    always_comb begin
        w_head         = '0;
        w_head.op      = t_op'(i_operation);
        w_head.row_sel = i_row_select;
        w_head.elem[0] = i_elem_0;
        w_head.elem[1] = i_elem_1;
        w_head.elem[2] = i_elem_2;
        w_head.elem[3] = i_elem_3;
    end

    assign w_stage[0] = w_head;
    assign w_valid[0] = i_valid;
    assign o_ready    = w_ready[0];

    for (genvar g = 0; g < N_DIM; g++) begin : g_cell
        mrm_cell #(
            .ROW_IDX(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_valid[g]),
            .i_stage     (w_stage[g]),
            .o_ready     (w_ready[g]),
            .i_next_ready(w_ready[g+1]),
            .o_valid     (w_valid[g+1]),
            .o_stage     (w_stage[g+1])
        );
    end

    mrm_round #(
        .FRAC_BITS(FRAC_BITS)
    ) u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[N_DIM]),
        .i_stage    (w_stage[N_DIM]),
        .o_ready    (w_ready[N_DIM]),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_prod     (w_prod),
        .o_saturated(o_saturated)
    );

    assign o_prod_0 = w_prod[0];
    assign o_prod_1 = w_prod[1];
    assign o_prod_2 = w_prod[2];
    assign o_prod_3 = w_prod[3];

endmodule

`default_nettype wire

### rtl/mrm_checker.sv
// Port-level checks for the row multiplier, bound to the top level.
// Depends on matrix4x4_row_multiply_assert.svh.
`default_nettype none

`include "matrix4x4_row_multiply_assert.svh"

module mrm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_prod_0,
    input logic signed [31:0] o_prod_1,
    input logic signed [31:0] o_prod_2,
    input logic signed [31:0] o_prod_3,
    input logic               o_saturated
);

    logic w_any_limit;

    assign w_any_limit = (o_prod_0 == 32'h7FFF_FFFF) || (o_prod_0 == 32'h8000_0000)
                      || (o_prod_1 == 32'h7FFF_FFFF) || (o_prod_1 == 32'h8000_0000)
                      || (o_prod_2 == 32'h7FFF_FFFF) || (o_prod_2 == 32'h8000_0000)
                      || (o_prod_3 == 32'h7FFF_FFFF) || (o_prod_3 == 32'h8000_0000);

    // a stalled result holds
    `MRM_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_prod_0) && $stable(o_prod_1) && $stable(o_prod_2) && $stable(o_prod_3) && $stable(o_saturated), "result changed while stalled")

    // a clipped row carries at least one limit value
    `MRM_ASSERT_NOW(a_sat_limit, o_valid && o_saturated, w_any_limit, "saturated flag without a limit value")

    // input back-pressure only comes from a stalled output
    `MRM_ASSERT_NOW(a_stall_source, !o_ready, o_valid && !i_ready, "input stalled with output free")

    // an empty output register leaves the chain free to take a request
    `MRM_ASSERT_NOW(a_empty_ready, !o_valid, o_ready, "input not ready with empty output")

endmodule

bind matrix4x4_row_multiply mrm_checker u_mrm_checker (.*);

`default_nettype wire

### tb/matrix4x4_row_multiply_tb.sv
// Self-checking testbench for matrix4x4_row_multiply: Q16.16 row-times-matrix products.
// Depends on mrm_pkg for the request codes and word type; needs nothing beyond the RTL.
`timescale 1ns / 100ps

module matrix4x4_row_multiply_tb;
    import mrm_pkg::*;

    localparam int unsigned FRAC_BITS      = 16;
    localparam int unsigned RANDOM_ROWS    = 1850;
    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned HOLD_AT        = 1200;

    localparam t_word Q_ONE   = 32'h0001_0000;
    localparam t_word Q_HALF  = 32'h0000_8000;
    localparam t_word Q_QUART = 32'h0000_4000;
    localparam t_word W_MAX   = 32'h7FFF_FFFF;
    localparam t_word W_MIN   = 32'h8000_0000;
    localparam t_word W_ONES  = 32'hFFFF_FFFF;
    localparam t_word W_ALT_A = 32'hAAAA_AAAA;
    localparam t_word W_ALT_5 = 32'h5555_5555;

    typedef struct packed {
        t_word [3:0] prod;
        logic        saturated;
    } t_row_result;

    class product_row_scoreboard;
        t_word       right_rows [16];
        t_row_result expected_rows [$];
        int unsigned mismatches, loads, multiplies, checked, clipped_rows;

        function new();
            foreach (right_rows[i]) right_rows[i] = '0;
        endfunction

        // Full-width dot products, floor shift, clip to 32 bits
        function t_row_result product_row(t_word [3:0] left);
            t_row_result        r;
            logic signed [65:0] acc;
            logic signed [65:0] shifted;
            r.saturated = 1'b0;
            for (int c = 0; c < 4; c++) begin
                acc = '0;
                for (int k = 0; k < 4; k++)
                    acc = acc + $signed(left[k]) * $signed(right_rows[k * 4 + c]);
                shifted = acc >>> FRAC_BITS;
                if (shifted > 66'sd2147483647) begin
                    r.prod[c]   = W_MAX;
                    r.saturated = 1'b1;
                end else if (shifted < -66'sd2147483648) begin
                    r.prod[c]   = W_MIN;
                    r.saturated = 1'b1;
                end else begin
                    r.prod[c] = shifted[31:0];
                end
            end
            return r;
        endfunction

        function void note_request(t_op op, logic [1:0] row, t_word [3:0] elem);
            if (op == OP_LOAD) begin
                loads++;
                for (int j = 0; j < 4; j++) right_rows[row * 4 + j] = elem[j];
            end else begin
                multiplies++;
                expected_rows.push_back(product_row(elem));
            end
        endfunction

        function void check_result(t_word [3:0] prod, logic sat);
            t_row_result want;
            if (expected_rows.size() == 0) begin
                $error("result row with nothing expected: %h %h %h %h sat %b",
                       prod[0], prod[1], prod[2], prod[3], sat);
                mismatches++;
                return;
            end
            want = expected_rows.pop_front();
            checked++;
            if (want.saturated) clipped_rows++;
            for (int c = 0; c < 4; c++)
                if (prod[c] !== want.prod[c]) begin
                    $error("prod_%0d: expected %h, got %h", c, want.prod[c], prod[c]);
                    mismatches++;
                end
            if (sat !== want.saturated) begin
                $error("saturated: expected %b, got %b", want.saturated, sat);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_rows.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_operation;
    logic [1:0]         i_row_select;
    logic signed [31:0] i_elem_0;
    logic signed [31:0] i_elem_1;
    logic signed [31:0] i_elem_2;
    logic signed [31:0] i_elem_3;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_prod_0;
    logic signed [31:0] o_prod_1;
    logic signed [31:0] o_prod_2;
    logic signed [31:0] o_prod_3;
    logic               o_saturated;

    product_row_scoreboard sb = new();
    int unsigned           sent_count;

    matrix4x4_row_multiply #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_row_select (i_row_select),
        .i_elem_0     (i_elem_0),
        .i_elem_1     (i_elem_1),
        .i_elem_2     (i_elem_2),
        .i_elem_3     (i_elem_3),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_prod_0     (o_prod_0),
        .o_prod_1     (o_prod_1),
        .o_prod_2     (o_prod_2),
        .o_prod_3     (o_prod_3),
        .o_saturated  (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_request(t_op'(i_operation), i_row_select,
                                {i_elem_3, i_elem_2, i_elem_1, i_elem_0});
            if (o_valid && i_ready)
                sb.check_result({o_prod_3, o_prod_2, o_prod_1, o_prod_0}, o_saturated);
        end
    end

    // Receiver: random stalls, a calm window, and one long hold-off to back the block up
    initial begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_count >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (sent_count >= 650 && sent_count < 950) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 28);
            end
        end
    end

    // End the run if nothing moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic offer_row(input t_op op, input logic [1:0] row, input t_word [3:0] elem,
                             input bit no_gap);
        while (!no_gap && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_row_select <= row;
        i_elem_0     <= elem[0];
        i_elem_1     <= elem[1];
        i_elem_2     <= elem[2];
        i_elem_3     <= elem[3];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // Mostly moderate Q16.16 values so products stay in range; some full-range and corners
    function automatic t_word pick_elem();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(6))
                    0: return '0;
                    1: return 32'h0000_0001;
                    2: return W_MAX;
                    3: return W_MIN;
                    4: return W_ONES;
                    5: return Q_ONE;
                    default: return 32'hFFFF_0000;
                endcase
            end
            1, 2: return $urandom;
            default: return t_word'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    initial begin
        t_word [3:0] elem;
        t_op         op;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_operation  <= OP_LOAD;
        i_row_select <= '0;
        i_elem_0     <= '0;
        i_elem_1     <= '0;
        i_elem_2     <= '0;
        i_elem_3     <= '0;
        sent_count   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing loaded yet: every product is zero
        offer_row(OP_MUL, 2'd3, {Q_ONE, W_ONES, W_MIN, W_MAX}, 1'b0);
        // Identity, then extremes pass straight through
        for (int r = 0; r < 4; r++) begin
            elem    = '0;
            elem[r] = Q_ONE;
            offer_row(OP_LOAD, 2'(r), elem, 1'b0);
        end
        offer_row(OP_MUL, 2'd2, {W_ALT_5, W_ALT_A, W_MIN, W_MAX}, 1'b0);
        offer_row(OP_MUL, 2'd1, {32'hFFFF_0000, 32'h0, 32'h1, W_ONES}, 1'b0);
        // Columns: all max, all min, a quarter, zero
        for (int r = 0; r < 4; r++)
            offer_row(OP_LOAD, 2'(r), {32'h0, Q_QUART, W_MIN, W_MAX}, 1'b0);
        // Clip high and low; quarter column lands exactly on the limit
        offer_row(OP_MUL, 2'd0, {W_MAX, W_MAX, W_MAX, W_MAX}, 1'b0);
        // Four min-by-min products exceed 64 bits
        offer_row(OP_MUL, 2'd3, {W_MIN, W_MIN, W_MIN, W_MIN}, 1'b0);
        // Floor shift on small negatives
        offer_row(OP_MUL, 2'd0, {32'h0, 32'h0, 32'h0, W_ONES}, 1'b0);
        offer_row(OP_MUL, 2'd1, {32'h0, 32'h0, 32'h0, 32'h1}, 1'b0);
        offer_row(OP_MUL, 2'd2, {32'h0, 32'hFFFF_0000, Q_ONE, Q_ONE}, 1'b0);
        offer_row(OP_LOAD, 2'd1, {32'h1, W_ONES, W_ALT_A, W_ALT_5}, 1'b0);
        offer_row(OP_LOAD, 2'd2, {W_ONES, 32'h1, W_ALT_5, W_ALT_A}, 1'b0);
        offer_row(OP_MUL, 2'd3, {Q_HALF, Q_HALF, Q_HALF, Q_HALF}, 1'b0);
        offer_row(OP_MUL, 2'd0, {W_ALT_A, W_ALT_5, W_ALT_A, W_ALT_5}, 1'b0);

        for (int unsigned n = 0; n < RANDOM_ROWS; n++) begin
            op = ($urandom_range(99) < 30) ? OP_LOAD : OP_MUL;
            for (int j = 0; j < 4; j++) elem[j] = pick_elem();
            offer_row(op, 2'($urandom_range(3)), elem, (n >= 600 && n < 900));
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d matrix row loads and %0d row multiplies", sb.loads, sb.multiplies);
        $display("checked %0d product rows, %0d of them clipped", sb.checked, sb.clipped_rows);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
